[sv/nsfp_pkg.sv]
// Package for the NMEA sentence field parser: character codes, limits,
// register defaults and the types shared between the parser modules.
// No dependencies.
package nsfp_pkg;

  // body limits
  localparam int MAX_BODY_BYTES  = 256;
  localparam int MAX_FIELD_COUNT = 63;
  localparam int BODY_LEN_W      = $clog2(MAX_BODY_BYTES + 1);
  localparam int FIELD_W         = 6;
  localparam int COMMA_W         = 6;
  localparam int CFG_IDX_W       = 3;

  // mantissa magnitude and its saturation point
  localparam int MAG_W = 31;
  localparam logic [MAG_W-1:0] MAG_LIMIT      = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] MAG_TENTH      = MAG_LIMIT / 10;
  localparam logic [3:0]       MAG_LAST_DIGIT = 4'(MAG_LIMIT % 10);
  localparam logic [3:0]       FRAC_MAX       = 4'd15;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] EMPTY_MARK = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RMC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VTG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GGA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLL = 3'd3;

  // configuration defaults
  localparam logic [COMMA_W-1:0] RMC_COMMAS_RST = 6'd12;
  localparam logic [COMMA_W-1:0] VTG_COMMAS_RST = 6'd9;
  localparam logic [COMMA_W-1:0] GGA_COMMAS_RST = 6'd14;
  localparam logic [COMMA_W-1:0] GLL_COMMAS_RST = 6'd7;

  typedef enum logic [2:0] {
    ST_RMC = 3'd0,
    ST_VTG = 3'd1,
    ST_GGA = 3'd2,
    ST_GSA = 3'd3,
    ST_GSV = 3'd4,
    ST_GLL = 3'd5
  } sent_type_t;

  typedef enum logic [3:0] {
    HS_IDLE,
    HS_DOLLAR,
    HS_G,
    HS_GP,
    HS_GPR,
    HS_GPV,
    HS_GPG,
    HS_GPRM,
    HS_GPVT,
    HS_GPGG,
    HS_GPGS,
    HS_GPGL,
    HS_BODY
  } hdr_state_t;

  typedef struct packed {
    logic [COMMA_W-1:0] rmc;
    logic [COMMA_W-1:0] vtg;
    logic [COMMA_W-1:0] gga;
    logic [COMMA_W-1:0] gll;
  } cfg_commas_t;

  // decisions of the body control for one character
  typedef struct packed {
    logic               emit;
    logic               last;
    logic               ok;
    logic               leave;
    logic               clear_field;
    logic               take;
    logic [FIELD_W-1:0] field_number;
  } body_ctl_t;

  // contents of the field being collected
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [3:0]       frac;
    logic [7:0]       first;
    logic             nonempty;
    logic             ovf;
  } field_val_t;

endpackage

[sv/nsfp_header_fsm.sv]
// Header matcher: tracks $GPxxx recognition and body occupancy and holds
// the sentence type. Depends on nsfp_pkg.
module nsfp_header_fsm import nsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] c,
  input  logic       body_leave,
  output logic       in_body,
  output sent_type_t cur_type
);

  hdr_state_t state, state_next;
  sent_type_t type_next;

  // next state and type
  always_comb begin
    state_next = state;
    type_next  = cur_type;
    if (step) begin
      unique case (state)
        HS_IDLE:   if (c == CH_DOLLAR) state_next = HS_DOLLAR;
        HS_DOLLAR: state_next = (c == CH_G) ? HS_G : HS_IDLE;
        HS_G:      state_next = (c == CH_P) ? HS_GP : HS_IDLE;
        HS_GP: begin
          priority if (c == CH_R) state_next = HS_GPR;
          else if (c == CH_V)     state_next = HS_GPV;
          else if (c == CH_G)     state_next = HS_GPG;
          else                    state_next = HS_IDLE;
        end
        HS_GPR:    state_next = (c == CH_M) ? HS_GPRM : HS_IDLE;
        HS_GPV:    state_next = (c == CH_T) ? HS_GPVT : HS_IDLE;
        HS_GPG: begin
          priority if (c == CH_G) state_next = HS_GPGG;
          else if (c == CH_S)     state_next = HS_GPGS;
          else if (c == CH_L)     state_next = HS_GPGL;
          else                    state_next = HS_IDLE;
        end
        HS_GPRM: begin
          state_next = (c == CH_C) ? HS_BODY : HS_IDLE;
          if (c == CH_C) type_next = ST_RMC;
        end
        HS_GPVT: begin
          state_next = (c == CH_G) ? HS_BODY : HS_IDLE;
          if (c == CH_G) type_next = ST_VTG;
        end
        HS_GPGG: begin
          state_next = (c == CH_A) ? HS_BODY : HS_IDLE;
          if (c == CH_A) type_next = ST_GGA;
        end
        HS_GPGS: begin
          priority if (c == CH_A) begin
            state_next = HS_BODY;
            type_next  = ST_GSA;
          end else if (c == CH_V) begin
            state_next = HS_BODY;
            type_next  = ST_GSV;
          end else begin
            state_next = HS_IDLE;
          end
        end
        HS_GPGL: begin
          state_next = (c == CH_L) ? HS_BODY : HS_IDLE;
          if (c == CH_L) type_next = ST_GLL;
        end
        HS_BODY:   if (body_leave) state_next = HS_IDLE;
        default:   state_next = HS_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    in_body = (state == HS_BODY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= HS_IDLE;
      cur_type <= ST_RMC;
    end else begin
      state    <= state_next;
      cur_type <= type_next;
    end
  end

endmodule

[sv/nsfp_body_ctrl.sv]
// Body control: comma and length counting, field emission, aborts and
// the sentence check at the star. Depends on nsfp_pkg.
module nsfp_body_ctrl import nsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  c,
  input  sent_type_t  cur_type,
  input  cfg_commas_t cfg,
  output body_ctl_t   ctl
);

  logic                  in_fields;
  logic [FIELD_W-1:0]    field_counter;
  logic [BODY_LEN_W-1:0] body_length;

  logic [FIELD_W:0]   commas;
  logic [COMMA_W-1:0] want;
  logic               want_ok;
  logic               too_long;
  logic               too_many;

  // comma count check against the configured count for the type
  always_comb begin
    commas  = in_fields ? ({1'b0, field_counter} + 7'd1) : '0;
    want    = '0;
    want_ok = 1'b1;
    unique case (cur_type)
      ST_RMC:  want = cfg.rmc;
      ST_VTG:  want = cfg.vtg;
      ST_GGA:  want = cfg.gga;
      ST_GLL:  want = cfg.gll;
      default: want_ok = 1'b0;
    endcase
  end

  assign too_long = (body_length >= BODY_LEN_W'(MAX_BODY_BYTES));
  assign too_many = (field_counter >= FIELD_W'(MAX_FIELD_COUNT));

  // per-character decision
  always_comb begin
    ctl              = '0;
    ctl.field_number = field_counter;
    priority if (c == CH_STAR) begin
      ctl.emit  = 1'b1;
      ctl.last  = 1'b1;
      ctl.ok    = want_ok && (commas == {1'b0, want});
      ctl.leave = 1'b1;
    end else if (too_long) begin
      ctl.leave = 1'b1;
    end else if (c == CH_COMMA) begin
      priority if (!in_fields) begin
        ctl.clear_field = 1'b1;
      end else if (too_many) begin
        ctl.leave = 1'b1;
      end else begin
        ctl.emit        = 1'b1;
        ctl.clear_field = 1'b1;
      end
    end else begin
      ctl.take = in_fields;
    end
  end

  // body counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_fields     <= 1'b0;
      field_counter <= '0;
      body_length   <= '0;
    end else if (step) begin
      if (ctl.leave) begin
        in_fields     <= 1'b0;
        field_counter <= '0;
        body_length   <= '0;
      end else begin
        body_length <= body_length + BODY_LEN_W'(1);
        if (c == CH_COMMA) begin
          if (in_fields) field_counter <= field_counter + FIELD_W'(1);
          in_fields <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/nsfp_field_acc.sv]
// Field accumulator: first character, sign, decimal magnitude with
// saturation and digits after the point. Depends on nsfp_pkg.
module nsfp_field_acc import nsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       take,
  input  logic [7:0] c,
  output field_val_t fv
);

  logic             is_digit;
  logic [3:0]       digit;
  logic             sat;
  logic [MAG_W+3:0] mag_x10;
  logic             point_seen;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = c[3:0];
  assign sat      = (fv.mag > MAG_TENTH) ||
                    ((fv.mag == MAG_TENTH) && (digit > MAG_LAST_DIGIT));
  // times ten as shift and add
  assign mag_x10  = ({4'b0, fv.mag} << 3) + ({4'b0, fv.mag} << 1)
                    + {{MAG_W{1'b0}}, digit};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fv.mag      <= '0;
      fv.neg      <= 1'b0;
      fv.frac     <= '0;
      fv.first    <= EMPTY_MARK;
      fv.nonempty <= 1'b0;
      fv.ovf      <= 1'b0;
      point_seen  <= 1'b0;
    end else if (take) begin
      // first character and sign
      if (!fv.nonempty) begin
        fv.first <= c;
        if (c == CH_MINUS) fv.neg <= 1'b1;
      end
      fv.nonempty <= 1'b1;
      // digit accumulate
      if (is_digit) begin
        if (sat) begin
          fv.mag <= MAG_LIMIT;
          fv.ovf <= 1'b1;
        end else begin
          fv.mag <= mag_x10[MAG_W-1:0];
        end
        if (point_seen && (fv.frac < FRAC_MAX)) fv.frac <= fv.frac + 4'd1;
      end else if (c == CH_POINT) begin
        point_seen <= 1'b1;
      end
    end
  end

endmodule

[sv/nmea_sentence_field_parser.sv]
// NMEA sentence field parser top level: input beat register, config
// registers and result register. Depends on nsfp_pkg and the nsfp_* modules.
//
// Takes one received character per beat and gives one result beat for each
// completed field of a $GPRMC, $GPVTG, $GPGGA, $GPGSA, $GPGSV or $GPGLL
// sentence, the star closing the last field with sentence_end set. A new
// character is taken every clock cycle unless in_stall is high; it passes
// the input register and the parsing logic, and a field's result is held in
// the result register until taken. in_stall rises only while both the input
// and result registers are full and out_stall is high. The user must write
// the expected-comma registers through cfg_wr_en/cfg_index/cfg_data only
// while no sentence is in flight; the block itself does not enforce this.
module nmea_sentence_field_parser import nsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // character input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COMMA_W-1:0]   cfg_data,
  // field results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           sentence_type,
  output logic [FIELD_W-1:0]   field_number,
  output logic signed [31:0]   mantissa,
  output logic [3:0]           fraction_digits,
  output logic [7:0]           leading_char,
  output logic                 field_is_empty,
  output logic                 value_saturated,
  output logic                 sentence_end,
  output logic                 sentence_ok
);

  logic        in_q_valid;
  logic [7:0]  byte_q;
  logic        adv;
  logic        in_body;
  logic        body_step;
  sent_type_t  cur_type;
  cfg_commas_t cfg;
  body_ctl_t   ctl;
  field_val_t  fv;
  logic [31:0] mag_ext;

  // stage advance when the result register can take a beat
  assign adv      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !adv;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (adv) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_q <= rx_byte;
  end

  // expected comma registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rmc <= RMC_COMMAS_RST;
      cfg.vtg <= VTG_COMMAS_RST;
      cfg.gga <= GGA_COMMAS_RST;
      cfg.gll <= GLL_COMMAS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RMC: cfg.rmc <= cfg_data;
        CFG_VTG: cfg.vtg <= cfg_data;
        CFG_GGA: cfg.gga <= cfg_data;
        CFG_GLL: cfg.gll <= cfg_data;
        default: ;
      endcase
    end
  end

  nsfp_header_fsm u_hdr (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .c          (byte_q),
    .body_leave (ctl.leave),
    .in_body    (in_body),
    .cur_type   (cur_type)
  );

  assign body_step = adv && in_body;

  nsfp_body_ctrl u_body (
    .clk      (clk),
    .rst      (rst),
    .step     (body_step),
    .c        (byte_q),
    .cur_type (cur_type),
    .cfg      (cfg),
    .ctl      (ctl)
  );

  nsfp_field_acc u_field (
    .clk   (clk),
    .rst   (rst),
    .clear (body_step && (ctl.clear_field || ctl.leave)),
    .take  (body_step && ctl.take),
    .c     (byte_q),
    .fv    (fv)
  );

  // signed mantissa from magnitude and sign
  assign mag_ext = {1'b0, fv.mag};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (body_step && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (body_step && ctl.emit) begin
      sentence_type   <= cur_type;
      field_number    <= ctl.field_number;
      mantissa        <= fv.neg ? -mag_ext : mag_ext;
      fraction_digits <= fv.frac;
      leading_char    <= fv.first;
      field_is_empty  <= !fv.nonempty;
      value_saturated <= fv.ovf;
      sentence_end    <= ctl.last;
      sentence_ok     <= ctl.ok;
    end
  end

endmodule
